FILE: rtl/ifsbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsbd_pkg
// shared types and constants of the imu frame sync and bcd decoder
// ----------------------------------------------------------------------------
package ifsbd_pkg;

  localparam int FRAME_LENGTH_DEF = 29;
  localparam int BYTE_W           = 8;
  localparam int FIELD_W          = 17;
  localparam int NUM_FIELDS       = 6;
  localparam int OUT_DATA_W       = ((NUM_FIELDS * FIELD_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h84;
  localparam logic signed [FIELD_W-1:0] ANGLE_WRAP = 17'sd36000;

  // byte index of the first byte of each field in the frame
  localparam int ROLL_AT   = 1;
  localparam int PITCH_AT  = 4;
  localparam int YAW_AT    = 7;
  localparam int RATE_X_AT = 19;
  localparam int RATE_Y_AT = 22;
  localparam int RATE_Z_AT = 25;

  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
  } field_bytes_t;

endpackage

FILE: rtl/imu_frame_sync_bcd_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_sync_bcd_decoder
// header sync, frame capture in a row of byte cells and six-field bcd decode
// ----------------------------------------------------------------------------
// the result word passes through the fire, dec_valid and output registers
// after the last frame byte is accepted
// throughput: one byte per cycle while s_tready is high, set by the byte cell shift line
// s_tready drops only on the frame-ending byte while the previous result
// is still in the decode stages or unsent
// reset (rst, synchronous): position back to header search, pipeline
// emptied, header_byte back to 0x84; the byte cells are not cleared
module imu_frame_sync_bcd_decoder
  import ifsbd_pkg::*;
#(
  parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [BYTE_W-1:0]     cfg_wr_data,   // header_byte
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,       // rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata        // roll, pitch, yaw, rate_x, rate_y, rate_z, pad
);

  localparam int POS_W = $clog2(FRAME_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

  logic [BYTE_W-1:0] header_byte;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic              take;
  logic              last;
  logic              fire;
  logic              dec_valid;

  logic [BYTE_W-1:0] cells [FRAME_LENGTH];

  field_bytes_t              fb     [NUM_FIELDS];
  logic signed [FIELD_W-1:0] res    [NUM_FIELDS];
  logic                      wrap_f [NUM_FIELDS];

  assign s_tready = !((pos == LAST_POS) && (fire || dec_valid || m_tvalid));
  assign take     = s_tvalid && s_tready && ((pos != '0) || (s_tdata == header_byte));
  assign last     = take && (pos == LAST_POS);

  always_comb begin
    pos_next = pos;
    if (last) begin
      pos_next = '0;
    end else if (take) begin
      pos_next = pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      pos         <= '0;
      fire        <= 1'b0;
      dec_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        header_byte <= cfg_wr_data;
      end
      pos       <= pos_next;
      fire      <= last;
      dec_valid <= fire;
    end
  end

  // newest byte in cell 0
  genvar gi;
  generate
    for (gi = 0; gi < FRAME_LENGTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        ifsbd_byte_cell u_cell (
          .clk   (clk),
          .shift (take),
          .d_in  (s_tdata),
          .q     (cells[gi])
        );
      end else begin : g_rest
        ifsbd_byte_cell u_cell (
          .clk   (clk),
          .shift (take),
          .d_in  (cells[gi-1]),
          .q     (cells[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    fb[0] = '{cells[FRAME_LENGTH-1-ROLL_AT],   cells[FRAME_LENGTH-2-ROLL_AT],
              cells[FRAME_LENGTH-3-ROLL_AT]};
    fb[1] = '{cells[FRAME_LENGTH-1-PITCH_AT],  cells[FRAME_LENGTH-2-PITCH_AT],
              cells[FRAME_LENGTH-3-PITCH_AT]};
    fb[2] = '{cells[FRAME_LENGTH-1-YAW_AT],    cells[FRAME_LENGTH-2-YAW_AT],
              cells[FRAME_LENGTH-3-YAW_AT]};
    fb[3] = '{cells[FRAME_LENGTH-1-RATE_X_AT], cells[FRAME_LENGTH-2-RATE_X_AT],
              cells[FRAME_LENGTH-3-RATE_X_AT]};
    fb[4] = '{cells[FRAME_LENGTH-1-RATE_Y_AT], cells[FRAME_LENGTH-2-RATE_Y_AT],
              cells[FRAME_LENGTH-3-RATE_Y_AT]};
    fb[5] = '{cells[FRAME_LENGTH-1-RATE_Z_AT], cells[FRAME_LENGTH-2-RATE_Z_AT],
              cells[FRAME_LENGTH-3-RATE_Z_AT]};
  end

  generate
    for (gi = 0; gi < NUM_FIELDS; gi++) begin : g_dec
      assign wrap_f[gi] = (gi < 3);
      ifsbd_field_decode u_dec (
        .clk      (clk),
        .load     (fire),
        .wrap     (wrap_f[gi]),
        .bytes_in (fb[gi]),
        .result   (res[gi])
      );
    end
  endgenerate

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dec_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid) begin
      m_tdata <= {(OUT_DATA_W - NUM_FIELDS * FIELD_W)'(0),
                  res[5], res[4], res[3], res[2], res[1], res[0]};
    end
  end

endmodule

FILE: rtl/ifsbd_byte_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsbd_byte_cell
// one byte of the frame shift line, handed on to the next cell on each shift
// ----------------------------------------------------------------------------
module ifsbd_byte_cell
  import ifsbd_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [BYTE_W-1:0] d_in,
  output logic [BYTE_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d_in;
    end
  end

endmodule

FILE: rtl/ifsbd_field_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsbd_field_decode
// sign-magnitude bcd field: registered magnitude, then sign and angle wrap
// ----------------------------------------------------------------------------
module ifsbd_field_decode
  import ifsbd_pkg::*;
(
  input  logic                      clk,
  input  logic                      load,
  input  logic                      wrap,
  input  field_bytes_t              bytes_in,
  output logic signed [FIELD_W-1:0] result
);

  logic [17:0] sum;
  logic [15:0] mag;
  logic        neg;
  logic signed [FIELD_W-1:0] pos_val;
  logic signed [FIELD_W-1:0] neg_val;

  assign sum = 18'(bytes_in.b0[3:0]) * 18'd10000
             + 18'(bytes_in.b1[7:4]) * 18'd1000
             + 18'(bytes_in.b1[3:0]) * 18'd100
             + 18'(bytes_in.b2[7:4]) * 18'd10
             + 18'(bytes_in.b2[3:0]);

  always_ff @(posedge clk) begin
    if (load) begin
      mag <= sum[15:0];
      neg <= (bytes_in.b0[7:4] != 4'd0);
    end
  end

  always_comb begin
    pos_val = signed'({1'b0, mag});
    neg_val = -pos_val;
    if (!neg) begin
      result = pos_val;
    end else if (wrap && (mag != 16'd0)) begin
      result = neg_val + ANGLE_WRAP;
    end else begin
      result = neg_val;
    end
  end

endmodule

FILE: rtl/ifsbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsbd_checker
// port-level checks of the imu frame sync and bcd decoder
// ----------------------------------------------------------------------------
module ifsbd_checker
  import ifsbd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // a new word follows a frame-ending byte, passed on through fire and dec_valid
  a_word_after_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
    else $error("output word without frame-ending byte");

  // frames are far apart, so a taken word is never followed at once
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid)
    else $error("two result words in consecutive cycles");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind imu_frame_sync_bcd_decoder ifsbd_checker u_ifsbd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the imu frame sync and bcd decoder: byte words are
// fed in frames with noise and broken frames between them, each decoded
// result word is checked field by field against a predictor kept in step
// with every accepted byte, over several header_byte settings
// ----------------------------------------------------------------------------
module testbench;
  import ifsbd_pkg::*;

  typedef logic [BYTE_W-1:0]               byte_t;
  typedef logic [FIELD_W-1:0]              field_t;
  typedef logic [NUM_FIELDS*FIELD_W-1:0]   attitude_t;
  typedef logic [NUM_FIELDS*24-1:0]        frame_fields_t;

  localparam int QUIET_LIMIT  = 3000;
  localparam int PHASE_BYTES  = 230;
  localparam int RAND_PHASES  = 6;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  byte_t                 cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  byte_t                 s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  byte_t     rx_bytes_q[$];
  attitude_t decoded_q[$];

  byte_t      hdr_model = HEADER_RESET;
  logic [4:0] frame_pos = '0;
  byte_t      frame_mem[32];

  int err_count = 0;
  int quiet     = 0;
  int s_gap     = 0;
  int s_calm    = 0;
  int m_gap     = 0;
  int m_calm    = 0;

  imu_frame_sync_bcd_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always #4 clk = ~clk;

  function automatic field_t bcd_value(int at, bit wrap);
    int b0;
    int b1;
    int b2;
    int mag;
    int v;
    b0  = int'(frame_mem[at & 31]);
    b1  = int'(frame_mem[(at + 1) & 31]);
    b2  = int'(frame_mem[(at + 2) & 31]);
    mag = (b0 & 15) * 10000 + (b1 >> 4) * 1000 + (b1 & 15) * 100
        + (b2 >> 4) * 10 + (b2 & 15);
    mag = mag & 'hFFFF;
    v   = ((b0 & 'hF0) != 0) ? -mag : mag;
    if (wrap && v < 0) begin
      v = v + int'(ANGLE_WRAP);
    end
    return field_t'(v);
  endfunction

  function automatic void sync_and_decode(byte_t b);
    if (frame_pos == 0 && b != hdr_model) begin
      return;
    end
    frame_mem[frame_pos] = b;
    frame_pos = frame_pos + 5'd1;
    if (frame_pos != 0 && frame_pos < FRAME_LENGTH_DEF) begin
      return;
    end
    frame_pos = '0;
    decoded_q.push_back({bcd_value(RATE_Z_AT, 1'b0), bcd_value(RATE_Y_AT, 1'b0),
                         bcd_value(RATE_X_AT, 1'b0), bcd_value(YAW_AT, 1'b1),
                         bcd_value(PITCH_AT, 1'b1), bcd_value(ROLL_AT, 1'b1)});
  endfunction

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] rand_field();
    logic [23:0] f;
    f[23:20] = ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
    for (int k = 0; k < 5; k++) begin
      f[k*4 +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
    end
    if ($urandom_range(0, 19) == 0) begin
      f[19:0] = '0;
    end
    return f;
  endfunction

  task automatic queue_field(logic [23:0] f);
    rx_bytes_q.push_back(f[23:16]);
    rx_bytes_q.push_back(f[15:8]);
    rx_bytes_q.push_back(f[7:0]);
  endtask

  task automatic queue_frame(byte_t hdr, frame_fields_t flds, byte_t fill, bit rand_fill);
    rx_bytes_q.push_back(hdr);
    for (int i = 0; i < 3; i++) queue_field(flds[i*24 +: 24]);
    for (int i = 0; i < 9; i++) rx_bytes_q.push_back(rand_fill ? byte_t'($urandom) : fill);
    for (int i = 3; i < 6; i++) queue_field(flds[i*24 +: 24]);
    for (int i = 28; i < FRAME_LENGTH_DEF; i++) begin
      rx_bytes_q.push_back(rand_fill ? byte_t'($urandom) : fill);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (rx_bytes_q.size() != 0 || s_tvalid || decoded_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_header(byte_t v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    hdr_model    = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // word source
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_gap > 0) begin
        s_gap = s_gap - 1;
        s_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= rx_bytes_q.pop_front();
        s_gap     = pick_gap(s_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_gap > 0) begin
      m_gap = m_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      m_gap     = pick_gap(m_calm);
    end
  end

  // checker and watchdog
  always @(posedge clk) begin : mon
    attitude_t want;
    field_t    got_f;
    field_t    want_f;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected result word %h", m_tdata);
        end else begin
          want = decoded_q.pop_front();
          for (int i = 0; i < NUM_FIELDS; i++) begin
            got_f  = m_tdata[i*FIELD_W +: FIELD_W];
            want_f = want[i*FIELD_W +: FIELD_W];
            if (got_f !== want_f) begin
              err_count++;
              if (err_count <= 10) begin
                $display("field %0d mismatch: expected %0d, got %0d", i,
                         $signed(want_f), $signed(got_f));
              end
            end
          end
        end
      end
      if (s_tvalid && s_tready) sync_and_decode(s_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_wr_en) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int    n;
    int    r;
    byte_t hdr;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames at the reset header
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(HEADER_RESET - 8'd1);
    rx_bytes_q.push_back(HEADER_RESET + 8'd1);
    queue_frame(HEADER_RESET, '0, 8'h00, 1'b0);
    queue_frame(HEADER_RESET, {6{24'h099999}}, 8'hFF, 1'b0);
    // header value inside the frame is plain data
    queue_frame(HEADER_RESET, {6{24'hF99999}}, HEADER_RESET, 1'b0);
    // non-bcd digits wrap modulo 65536
    queue_frame(HEADER_RESET, {6{24'hFFFFFF}}, 8'h55, 1'b0);
    // negative zero
    queue_frame(HEADER_RESET, {6{24'h100000}}, 8'hAA, 1'b0);
    queue_frame(HEADER_RESET, {24'h036000, 24'h835999, 24'h065536, 24'h165535,
                               24'h000001, 24'h800001}, HEADER_RESET, 1'b0);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       hdr = 8'h00;
        1:       hdr = 8'hFF;
        5:       hdr = HEADER_RESET;
        default: hdr = byte_t'($urandom_range(0, 255));
      endcase
      write_header(hdr);
      n = 0;
      while (n < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          repeat ($urandom_range(1, 6)) rx_bytes_q.push_back(byte_t'($urandom));
        end else if (r < 25) begin
          rx_bytes_q.push_back(hdr);
          repeat ($urandom_range(1, FRAME_LENGTH_DEF - 2)) begin
            rx_bytes_q.push_back(byte_t'($urandom));
            n++;
          end
        end else begin
          queue_frame(hdr, {rand_field(), rand_field(), rand_field(), rand_field(),
                            rand_field(), rand_field()}, 8'h00, 1'b1);
          n += FRAME_LENGTH_DEF;
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    err_count += decoded_q.size();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
